// File: design/dbhq_pkg.sv
// ----------------------------------------------------------------------------
// dbhq_pkg
// Types, register indexes and constants for the dual button hold qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package dbhq_pkg;

  localparam int NUM_BUTTONS = 2;
  localparam int TIME_WIDTH_DEF = 32;

  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int STABLE_W = 8;
  localparam int SETTLE_CNT_W = 9;
  localparam int BOTH_CNT_W = 3;

  localparam logic [BOTH_CNT_W-1:0] BOTH_LIMIT = 3'd5;
  localparam logic [BOTH_CNT_W-1:0] BOTH_SAT = 3'd6;

  localparam logic [CFG_W-1:0] SETTLE_TIME_RST = 16'd10;
  localparam logic [STABLE_W-1:0] STABLE_COUNT_RST = 8'd3;
  localparam logic [CFG_W-1:0] HOLD_TIME_RST = 16'd1000;
  localparam logic [CFG_W-1:0] BOTH_INTERVAL_RST = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETTLE_TIME   = 2'd0,
    REG_STABLE_COUNT  = 2'd1,
    REG_HOLD_TIME     = 2'd2,
    REG_BOTH_INTERVAL = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_HOLD     = 2'd2
  } status_t;

  typedef struct packed {
    status_t status_first;
    status_t status_second;
    logic    reset_request;
  } result_t;

endpackage

`default_nettype wire

// File: design/dual_button_hold_qualifier.sv
// ----------------------------------------------------------------------------
// dual_button_hold_qualifier
// Debounces two active-low buttons, qualifies long presses as hold and
// raises a reset request while both buttons stay down long enough.
// ----------------------------------------------------------------------------
// An accepted poll's result is registered into the output or skid register.
// Throughput: one poll per cycle while in_stall is low; all per-poll work is one pass of compare
// logic from the button state registers into the output register.
// A two-entry output stage (output register plus skid register) keeps
// requests flowing while a result waits; in_stall rises only when both are full.
// Reset (synchronous, rst_n low) clears all button state, the both-counter and
// the output stage valid flags, and loads the default configuration values.
`default_nettype none

module dual_button_hold_qualifier
  import dbhq_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [TIME_WIDTH-1:0] in_now_time,
  input  wire logic                  in_level_first,
  input  wire logic                  in_level_second,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_status_first,
  output logic [1:0]                 out_status_second,
  output logic                       out_reset_request
);

  // Configuration registers.
  logic [CFG_W-1:0]    settle_time_r;
  logic [STABLE_W-1:0] stable_count_r;
  logic [CFG_W-1:0]    hold_time_r;
  logic [CFG_W-1:0]    both_interval_r;

  // Button state.
  logic                    last_level_r   [NUM_BUTTONS];
  logic [TIME_WIDTH-1:0]   settle_start_r [NUM_BUTTONS];
  logic [SETTLE_CNT_W-1:0] settle_count_r [NUM_BUTTONS];
  status_t                 status_r       [NUM_BUTTONS];
  logic [TIME_WIDTH-1:0]   press_start_r  [NUM_BUTTONS];
  logic [TIME_WIDTH-1:0]   both_start_r;
  logic [BOTH_CNT_W-1:0]   both_count_r;

  logic                    last_level_nxt   [NUM_BUTTONS];
  logic [TIME_WIDTH-1:0]   settle_start_nxt [NUM_BUTTONS];
  logic [SETTLE_CNT_W-1:0] settle_count_nxt [NUM_BUTTONS];
  status_t                 status_nxt       [NUM_BUTTONS];
  logic [TIME_WIDTH-1:0]   press_start_nxt  [NUM_BUTTONS];
  logic [TIME_WIDTH-1:0]   both_start_nxt;
  logic [BOTH_CNT_W-1:0]   both_count_nxt;

  // Per-button intermediate terms.
  logic                    level        [NUM_BUTTONS];
  logic                    changed      [NUM_BUTTONS];
  logic                    settle_rise  [NUM_BUTTONS];
  logic                    level_taken  [NUM_BUTTONS];
  logic [SETTLE_CNT_W-1:0] count_start  [NUM_BUTTONS];
  logic [SETTLE_CNT_W-1:0] count_risen  [NUM_BUTTONS];
  logic [TIME_WIDTH-1:0]   settle_el    [NUM_BUTTONS];
  logic [TIME_WIDTH-1:0]   press_el     [NUM_BUTTONS];
  status_t                 status_taken [NUM_BUTTONS];
  logic                    down         [NUM_BUTTONS];

  logic [TIME_WIDTH-1:0] settle_time_ext;
  logic [TIME_WIDTH-1:0] hold_time_ext;
  logic [TIME_WIDTH-1:0] both_interval_ext;
  logic [TIME_WIDTH-1:0] both_el;
  logic                  both_rise;
  logic                  req;

  // Output stage.
  result_t res_nxt;
  result_t out_r;
  result_t skid_r;
  logic    out_valid_r;
  logic    skid_valid_r;
  logic    in_acc;
  logic    out_free;

  assign in_acc   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = skid_valid_r;

  assign level[0] = in_level_first;
  assign level[1] = in_level_second;

  assign settle_time_ext   = TIME_WIDTH'(settle_time_r);
  assign hold_time_ext     = TIME_WIDTH'(hold_time_r);
  assign both_interval_ext = TIME_WIDTH'(both_interval_r);

  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      changed[b]   = last_level_r[b] != level[b];
      settle_el[b] = in_now_time - settle_start_r[b];
      press_el[b]  = in_now_time - press_start_r[b];
      count_start[b] = changed[b] ? SETTLE_CNT_W'(1) : settle_count_r[b];
      // A level change restarts the settle timer at this poll, so no time
      // has elapsed yet on that poll.
      settle_rise[b] = !changed[b] && (count_start[b] != '0) &&
                       (settle_el[b] > settle_time_ext);
      count_risen[b] = settle_rise[b] ? count_start[b] + SETTLE_CNT_W'(1)
                                      : count_start[b];
      level_taken[b] = count_risen[b] > SETTLE_CNT_W'(stable_count_r);

      last_level_nxt[b]   = level[b];
      settle_start_nxt[b] = (changed[b] || settle_rise[b]) ? in_now_time
                                                           : settle_start_r[b];
      settle_count_nxt[b] = level_taken[b] ? '0 : count_risen[b];

      if (level_taken[b]) begin
        status_taken[b] = level[b] ? ST_RELEASED : ST_PRESSED;
      end else begin
        status_taken[b] = status_r[b];
      end
      press_start_nxt[b] = (level_taken[b] && !level[b]) ? in_now_time
                                                         : press_start_r[b];

      // A press accepted on this poll has zero elapsed press time.
      if (status_taken[b] == ST_PRESSED && !(level_taken[b] && !level[b]) &&
          press_el[b] > hold_time_ext) begin
        status_nxt[b] = ST_HOLD;
      end else begin
        status_nxt[b] = status_taken[b];
      end
      down[b] = status_nxt[b] == ST_PRESSED || status_nxt[b] == ST_HOLD;
    end
  end

  assign both_el = in_now_time - both_start_r;

  always_comb begin
    both_rise      = down[0] && down[1] && (both_el > both_interval_ext);
    both_start_nxt = both_rise ? in_now_time : both_start_r;
    both_count_nxt = both_count_r;
    req            = 1'b0;
    if (down[0] && down[1]) begin
      if (both_rise) begin
        if (both_count_r < BOTH_SAT) begin
          both_count_nxt = both_count_r + BOTH_CNT_W'(1);
        end
        req = both_count_nxt > BOTH_LIMIT;
      end
    end else begin
      both_count_nxt = '0;
    end
  end

  always_comb begin
    res_nxt.status_first  = status_nxt[0];
    res_nxt.status_second = status_nxt[1];
    res_nxt.reset_request = req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_time_r   <= SETTLE_TIME_RST;
      stable_count_r  <= STABLE_COUNT_RST;
      hold_time_r     <= HOLD_TIME_RST;
      both_interval_r <= BOTH_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SETTLE_TIME:   settle_time_r   <= cfg_wdata;
        REG_STABLE_COUNT:  stable_count_r  <= cfg_wdata[STABLE_W-1:0];
        REG_HOLD_TIME:     hold_time_r     <= cfg_wdata;
        REG_BOTH_INTERVAL: both_interval_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        last_level_r[b]   <= 1'b0;
        settle_start_r[b] <= '0;
        settle_count_r[b] <= '0;
        status_r[b]       <= ST_RELEASED;
        press_start_r[b]  <= '0;
      end
      both_start_r <= '0;
      both_count_r <= '0;
    end else if (in_acc) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        last_level_r[b]   <= last_level_nxt[b];
        settle_start_r[b] <= settle_start_nxt[b];
        settle_count_r[b] <= settle_count_nxt[b];
        status_r[b]       <= status_nxt[b];
        press_start_r[b]  <= press_start_nxt[b];
      end
      both_start_r <= both_start_nxt;
      both_count_r <= both_count_nxt;
    end
  end

  // Output register with a skid entry behind it. While the skid entry is
  // full no request is taken, so it drains into the output register first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_acc) begin
        out_r <= res_nxt;
      end
    end else if (in_acc) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status_first  = out_r.status_first;
  assign out_status_second = out_r.status_second;
  assign out_reset_request = out_r.reset_request;

  // The skid entry is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // A reset request is only issued while both buttons are down.
  a_req_needs_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.reset_request |->
      (out_r.status_first != ST_RELEASED) && (out_r.status_second != ST_RELEASED))
    else $error("reset request without both buttons down");

  // The both-counter saturates and never passes its ceiling.
  a_both_sat: assert property (@(posedge clk) disable iff (!rst_n)
    both_count_r <= BOTH_SAT)
    else $error("both-counter above saturation value");

  // An accepted request always shows up in the output stage next cycle.
  a_acc_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted request lost in output stage");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives polls into the dual button hold qualifier under random valid gaps and
// result stalls. A scoreboard keeps its own debounce and hold state, predicts
// every result and compares it field by field. It runs through several
// register settings, the all-zero and all-ones extremes among them.
// ----------------------------------------------------------------------------
module testbench;
  import dbhq_pkg::*;

  localparam int TW = TIME_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400_000;

  class poll_scoreboard;
    logic [CFG_W-1:0]    t_settle;
    logic [STABLE_W-1:0] n_stable;
    logic [CFG_W-1:0]    t_hold;
    logic [CFG_W-1:0]    t_both;

    bit                      seen_level   [NUM_BUTTONS];
    logic [TW-1:0]           settle_mark  [NUM_BUTTONS];
    logic [SETTLE_CNT_W-1:0] settle_ticks [NUM_BUTTONS];
    status_t                 btn_status   [NUM_BUTTONS];
    logic [TW-1:0]           press_mark   [NUM_BUTTONS];
    logic [TW-1:0]           both_mark;
    logic [BOTH_CNT_W-1:0]   both_ticks;

    result_t pending_results[$];
    int      failures;

    function new();
      t_settle = SETTLE_TIME_RST;
      n_stable = STABLE_COUNT_RST;
      t_hold   = HOLD_TIME_RST;
      t_both   = BOTH_INTERVAL_RST;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        seen_level[b]   = 1'b0;
        settle_mark[b]  = '0;
        settle_ticks[b] = '0;
        btn_status[b]   = ST_RELEASED;
        press_mark[b]   = '0;
      end
      both_mark  = '0;
      both_ticks = '0;
      failures   = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_SETTLE_TIME:   t_settle = val;
        REG_STABLE_COUNT:  n_stable = val[STABLE_W-1:0];
        REG_HOLD_TIME:     t_hold   = val;
        REG_BOTH_INTERVAL: t_both   = val;
        default: ;
      endcase
    endfunction

    function void debounce(int b, bit level, logic [TW-1:0] stamp);
      logic [TW-1:0] dt;
      if (seen_level[b] != level) begin
        settle_mark[b]  = stamp;
        settle_ticks[b] = SETTLE_CNT_W'(1);
        seen_level[b]   = level;
      end
      dt = stamp - settle_mark[b];
      if (settle_ticks[b] != 0 && dt > TW'(t_settle)) begin
        settle_ticks[b] = settle_ticks[b] + 1'b1;
        settle_mark[b]  = stamp;
      end
      if (settle_ticks[b] > SETTLE_CNT_W'(n_stable)) begin
        settle_ticks[b] = '0;
        if (seen_level[b] == 1'b0) begin
          btn_status[b] = ST_PRESSED;
          press_mark[b] = stamp;
        end else begin
          btn_status[b] = ST_RELEASED;
        end
      end
      dt = stamp - press_mark[b];
      if (btn_status[b] == ST_PRESSED && dt > TW'(t_hold))
        btn_status[b] = ST_HOLD;
    endfunction

    function void note_poll(logic [TW-1:0] stamp, bit lvl0, bit lvl1);
      logic [TW-1:0] dt;
      result_t r;
      bit down0, down1;
      debounce(0, lvl0, stamp);
      debounce(1, lvl1, stamp);
      down0 = btn_status[0] == ST_PRESSED || btn_status[0] == ST_HOLD;
      down1 = btn_status[1] == ST_PRESSED || btn_status[1] == ST_HOLD;
      r.reset_request = 1'b0;
      if (down0 && down1) begin
        dt = stamp - both_mark;
        if (dt > TW'(t_both)) begin
          both_mark = stamp;
          if (both_ticks < BOTH_SAT)
            both_ticks = both_ticks + 1'b1;
          if (both_ticks > BOTH_LIMIT)
            r.reset_request = 1'b1;
        end
      end else begin
        // Releasing either button clears the count but keeps the interval mark.
        both_ticks = '0;
      end
      r.status_first  = btn_status[0];
      r.status_second = btn_status[1];
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] got_first, logic [1:0] got_second, logic got_req);
      result_t exp;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status_first %0d status_second %0d reset_request %0d",
               got_first, got_second, got_req);
        failures++;
        return;
      end
      exp = pending_results.pop_front();
      if (got_first !== exp.status_first) begin
        $error("status_first: expected %0d, got %0d", exp.status_first, got_first);
        failures++;
      end
      if (got_second !== exp.status_second) begin
        $error("status_second: expected %0d, got %0d", exp.status_second, got_second);
        failures++;
      end
      if (got_req !== exp.reset_request) begin
        $error("reset_request: expected %0d, got %0d", exp.reset_request, got_req);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [TW-1:0] in_now_time = '0;
  logic          in_level_first = 1'b1;
  logic          in_level_second = 1'b1;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status_first;
  logic [1:0] out_status_second;
  logic       out_reset_request;

  poll_scoreboard sb;
  int             rx_stall_max = 8;
  int             cycles = 0;

  // Stimulus state: current intended level and remaining run of each button.
  logic [TW-1:0] clock_now = '0;
  bit            cur_level [NUM_BUTTONS];
  int            run_left  [NUM_BUTTONS];

  dual_button_hold_qualifier DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_now_time      (in_now_time),
    .in_level_first   (in_level_first),
    .in_level_second  (in_level_second),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status_first (out_status_first),
    .out_status_second(out_status_second),
    .out_reset_request(out_reset_request)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_poll(in_now_time, in_level_first, in_level_second);
      if (out_valid && !out_stall)
        sb.check_result(out_status_first, out_status_second, out_reset_request);
    end
  end

  // Result side: random stall before each result, plus two long hold-offs that
  // let the block fill up and push back on incoming requests.
  initial begin : result_sink
    int stall_len;
    int taken;
    taken = 0;
    wait (rst_n);
    forever begin
      if (taken == 300 || taken == 900)
        stall_len = 200;
      else
        stall_len = $urandom_range(rx_stall_max);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  task automatic send_poll(input logic [TW-1:0] stamp, input bit lvl0, input bit lvl1,
                           input int gap_max);
    int gap;
    gap = $urandom_range(gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_now_time     <= stamp;
    in_level_first  <= lvl0;
    in_level_second <= lvl1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] st, input logic [CFG_W-1:0] sc,
                                input logic [CFG_W-1:0] ht, input logic [CFG_W-1:0] bi);
    logic [CFG_W-1:0] vals [4];
    vals = '{st, sc, ht, bi};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(cfg_reg_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic int run_length();
    int r;
    r = $urandom_range(9);
    if (r < 5)
      return $urandom_range(int'(sb.n_stable) + 4, 1);
    else if (r < 8)
      return $urandom_range(3 * int'(sb.n_stable) + 20, int'(sb.n_stable) + 2);
    else
      return $urandom_range(150, 20);
  endfunction

  task automatic run_random(input int n_items, input int gap_max);
    int r;
    bit lvl0, lvl1;
    logic [TW-1:0] dt;
    for (int k = 0; k < n_items; k++) begin
      if (run_left[0] <= 0) begin
        if ($urandom_range(3) != 0) cur_level[0] = ~cur_level[0];
        run_left[0] = run_length();
        // Half the time the second button follows, so both change level together.
        if ($urandom_range(1) == 1) begin
          cur_level[1] = cur_level[0];
          run_left[1] = run_left[0];
        end
      end
      if (run_left[1] <= 0) begin
        if ($urandom_range(3) != 0) cur_level[1] = ~cur_level[1];
        run_left[1] = run_length();
      end
      lvl0 = cur_level[0] ^ ($urandom_range(19) == 0);
      lvl1 = cur_level[1] ^ ($urandom_range(19) == 0);
      run_left[0]--;
      run_left[1]--;
      r = $urandom_range(19);
      if (r < 2)
        dt = '0;
      else if (r == 2)
        dt = $urandom;
      else if (r == 3)
        dt = $urandom_range(32'(sb.t_hold) + 32'(sb.t_both) + 2);
      else
        dt = $urandom_range(2 * 32'(sb.t_settle) + 2);
      clock_now = clock_now + dt;
      send_poll(clock_now, lvl0, lvl1, gap_max);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] plan [5][4];
    logic [CFG_W-1:0] st, sc, ht, bi;
    plan = '{'{16'd3, 16'd2, 16'd40, 16'd10},
             '{16'd10, 16'd3, 16'd1000, 16'd100},
             '{16'd1, 16'd1, 16'd20, 16'd5},
             '{16'd0, 16'd0, 16'd0, 16'd0},
             '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}};
    sb = new();
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      cur_level[b] = 1'b1;
      run_left[b]  = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A button low from reset is no change and stays released.
    send_poll(32'd0, 1'b0, 1'b0, 0);
    send_poll(32'hFFFF_FFFF, 1'b0, 1'b0, 0);
    in_valid <= 1'b0;
    wait_drained();

    // All-zero settings: accept on the poll that sees the change, move a pressed
    // button to hold once any press time has elapsed, and run the both-counter into saturation, then clear it.
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
    send_poll(32'd1, 1'b1, 1'b1, 0);
    send_poll(32'd2, 1'b0, 1'b1, 0);
    send_poll(32'd3, 1'b0, 1'b0, 0);
    send_poll(32'd3, 1'b0, 1'b0, 0);
    for (int t = 4; t < 10; t++)
      send_poll(TW'(t), 1'b0, 1'b0, 0);
    send_poll(32'd10, 1'b1, 1'b0, 0);
    send_poll(32'd11, 1'b0, 1'b0, 0);
    send_poll(32'hFFFF_FFFF, 1'b0, 1'b0, 0);
    send_poll(32'd0, 1'b0, 1'b0, 0);
    in_valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      if (p < 5) begin
        st = plan[p][0];
        sc = plan[p][1];
        ht = plan[p][2];
        bi = plan[p][3];
      end else begin
        st = CFG_W'($urandom_range(30));
        sc = {8'($urandom), 8'($urandom_range(6))};
        ht = CFG_W'($urandom_range(300));
        bi = CFG_W'($urandom_range(60));
      end
      apply_settings(st, sc, ht, bi);
      rx_stall_max = (p % 2 == 0) ? 8 : 0;
      run_random((p == 4) ? 80 : 185, (p % 4 < 2) ? 8 : 0);
      wait_drained();
    end

    if (sb.failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
